@@ hw/rtl/mlfq_pkg.sv @@
// Shared types, widths and constants of the two-level MLFQ scheduler.
package mlfq_pkg;

    localparam int ID_W       = 3;
    localparam int SLICE_W    = 8;
    localparam int ALLOT_W    = 10;
    localparam int TIME_W     = 16;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic LVL_TOP     = 1'b1;
    localparam logic LVL_LOW     = 1'b0;
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_TOP_SLICE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TOP_ALLOT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW_SLICE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_ALLOT = 2'd3;

    localparam logic [SLICE_W-1:0] TOP_SLICE_RST = 8'd3;
    localparam logic [ALLOT_W-1:0] TOP_ALLOT_RST = 10'd6;
    localparam logic [SLICE_W-1:0] LOW_SLICE_RST = 8'd10;
    localparam logic [ALLOT_W-1:0] LOW_ALLOT_RST = 10'd20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_PICK,
        ST_HEAD,
        ST_EXEC
    } sched_state_t;

    typedef struct packed {
        logic [SLICE_W-1:0] top_slice;
        logic [ALLOT_W-1:0] top_allot;
        logic [SLICE_W-1:0] low_slice;
        logic [ALLOT_W-1:0] low_allot;
    } cfg_t;

    typedef struct packed {
        logic [SLICE_W-1:0] slice_left;
        logic [ALLOT_W-1:0] allot_left;
        logic [TIME_W-1:0]  time_left;
    } job_rec_t;

    typedef struct packed {
        logic rd_en;
        logic rd_lvl;
        logic pop;
        logic pop_lvl;
        logic push;
        logic push_lvl;
    } queue_cmd_t;

    typedef struct packed {
        logic top_busy;
        logic low_busy;
    } queue_stat_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic arrive;
        logic run;
        logic finish;
    } job_cmd_t;

endpackage

@@ hw/rtl/mlfq_if.sv @@
// Valid/ready channel interfaces for scheduler requests and reports.
interface mlfq_req_if;
    import mlfq_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [ID_W-1:0]   arriving_job;
    logic [TIME_W-1:0] run_length;

    modport source (output valid, mode, arriving_job, run_length, input ready);
    modport sink   (input valid, mode, arriving_job, run_length, output ready);
endinterface

interface mlfq_rsp_if;
    import mlfq_pkg::*;

    logic              valid;
    logic              ready;
    logic              idle;
    logic [ID_W-1:0]   ran_job;
    logic              ran_level;
    logic              first_run;
    logic              finished;
    logic              demoted;
    logic [TIME_W-1:0] time_left;

    modport source (
        output valid, idle, ran_job, ran_level, first_run, finished, demoted, time_left,
        input  ready
    );
    modport sink (
        input  valid, idle, ran_job, ran_level, first_run, finished, demoted, time_left,
        output ready
    );
endinterface

@@ hw/rtl/mlfq_two_level_scheduler.sv @@
// Two-level MLFQ scheduler top: item sequencer, result register, submodule wiring.
// Arrival: accepted in IDLE; job record and queue written next, for a valid inactive id.
// Tick: accept, queue head read, job record read, update; the result is registered in the
// update step and the next item is then taken in IDLE; an idle tick reports from the head-read
// step, as two registered reads chain. A result not taken holds the tick in its last step.
// Reset empties both queues and clears the job flags at once; no clearing pass is needed.
module mlfq_two_level_scheduler #(
    parameter int JOBS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mlfq_req_if.sink                      request,
    mlfq_rsp_if.source                    report,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mlfq_pkg::ADDR_W-1:0]   paddr,
    input  logic [mlfq_pkg::DATA_W-1:0]   pwdata,
    output logic [mlfq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import mlfq_pkg::*;

    localparam int JIDX_W = $clog2(JOBS);

    typedef struct packed {
        logic              idle;
        logic [ID_W-1:0]   ran_job;
        logic              ran_level;
        logic              first_run;
        logic              finished;
        logic              demoted;
        logic [TIME_W-1:0] time_left;
    } rsp_t;

    sched_state_t      state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [ID_W-1:0]   job_reg, job_next;
    logic [TIME_W-1:0] len_reg, len_next;
    logic              lvl_reg, lvl_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    cfg_t              cfg;
    queue_cmd_t        q_cmd;
    queue_stat_t       q_stat;
    logic [JIDX_W-1:0] q_push_id;
    logic [JIDX_W-1:0] q_head_id;
    job_cmd_t          j_cmd;
    logic [JIDX_W-1:0] j_idx;
    job_rec_t          j_wr_rec;
    job_rec_t          j_rd_rec;
    logic              j_active;
    logic              j_started;

    logic              item_acc;
    logic              out_free;
    logic              arrive_ok;
    logic [SLICE_W-1:0] slice_dec;
    logic [ALLOT_W-1:0] allot_dec;
    logic [TIME_W-1:0]  time_dec;
    logic              fin;
    logic              slice_end;
    logic              dem;

    mlfq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlfq_queue #(.JOBS(JOBS)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (q_cmd),
        .push_id (q_push_id),
        .head_id (q_head_id),
        .stat    (q_stat)
    );

    mlfq_jobs #(.JOBS(JOBS)) u_jobs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (j_cmd),
        .idx     (j_idx),
        .wr_rec  (j_wr_rec),
        .rd_rec  (j_rd_rec),
        .active  (j_active),
        .started (j_started)
    );

    assign item_acc  = request.valid && request.ready;
    assign out_free  = !out_valid_reg || report.ready;
    assign arrive_ok = (int'(job_reg) < JOBS) && !j_active;

    // one tick of the head job, saturating at zero
    assign allot_dec = (j_rd_rec.allot_left != '0) ? j_rd_rec.allot_left - ALLOT_W'(1) : '0;
    assign time_dec  = (j_rd_rec.time_left != '0) ? j_rd_rec.time_left - TIME_W'(1) : '0;
    assign slice_dec = (j_rd_rec.slice_left != '0) ? j_rd_rec.slice_left - SLICE_W'(1) : '0;
    assign fin       = (time_dec == '0);
    assign slice_end = (slice_dec == '0);
    assign dem       = !fin && slice_end && (lvl_reg == LVL_TOP) && (allot_dec == '0);

    assign report.valid     = out_valid_reg;
    assign report.idle      = out_reg.idle;
    assign report.ran_job   = out_reg.ran_job;
    assign report.ran_level = out_reg.ran_level;
    assign report.first_run = out_reg.first_run;
    assign report.finished  = out_reg.finished;
    assign report.demoted   = out_reg.demoted;
    assign report.time_left = out_reg.time_left;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    state_next = (request.mode == MODE_TICK) ? ST_PICK : ST_ARRIVE;
                end
            end
            ST_ARRIVE:
            begin
                state_next = ST_IDLE;
            end
            ST_PICK:
            begin
                if (q_stat.top_busy || q_stat.low_busy)
                begin
                    state_next = ST_HEAD;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HEAD:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        request.ready  = 1'b0;
        mode_next      = mode_reg;
        job_next       = job_reg;
        len_next       = len_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg && !report.ready;
        out_next       = out_reg;
        q_cmd          = '0;
        q_push_id      = q_head_id;
        j_cmd          = '0;
        j_idx          = q_head_id;
        j_wr_rec       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                request.ready = 1'b1;
                if (item_acc)
                begin
                    mode_next = request.mode;
                    job_next  = request.arriving_job;
                    len_next  = request.run_length;
                end
            end
            ST_ARRIVE:
            begin
                j_idx     = JIDX_W'(job_reg);
                q_push_id = JIDX_W'(job_reg);
                if (arrive_ok)
                begin
                    j_cmd.wr_en         = 1'b1;
                    j_cmd.arrive        = 1'b1;
                    j_wr_rec.slice_left = cfg.top_slice;
                    j_wr_rec.allot_left = cfg.top_allot;
                    j_wr_rec.time_left  = len_reg;
                    q_cmd.push          = 1'b1;
                    q_cmd.push_lvl      = LVL_TOP;
                end
            end
            ST_PICK:
            begin
                if (q_stat.top_busy || q_stat.low_busy)
                begin
                    lvl_next     = q_stat.top_busy ? LVL_TOP : LVL_LOW;
                    q_cmd.rd_en  = 1'b1;
                    q_cmd.rd_lvl = q_stat.top_busy ? LVL_TOP : LVL_LOW;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.idle  = 1'b1;
                end
            end
            ST_HEAD:
            begin
                j_cmd.rd_en = 1'b1;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    j_cmd.wr_en         = 1'b1;
                    j_cmd.run           = 1'b1;
                    j_cmd.finish        = fin;
                    j_wr_rec.slice_left = slice_dec;
                    j_wr_rec.allot_left = allot_dec;
                    j_wr_rec.time_left  = time_dec;
                    if (!fin && slice_end)
                    begin
                        if (dem)
                        begin
                            j_wr_rec.slice_left = cfg.low_slice;
                            j_wr_rec.allot_left = cfg.low_allot;
                        end
                        else
                        begin
                            j_wr_rec.slice_left = (lvl_reg == LVL_TOP) ? cfg.top_slice
                                                                       : cfg.low_slice;
                        end
                    end
                    q_cmd.pop      = fin || slice_end;
                    q_cmd.pop_lvl  = lvl_reg;
                    q_cmd.push     = !fin && slice_end;
                    q_cmd.push_lvl = dem ? LVL_LOW : lvl_reg;

                    out_valid_next     = 1'b1;
                    out_next.idle      = 1'b0;
                    out_next.ran_job   = ID_W'(q_head_id);
                    out_next.ran_level = lvl_reg;
                    out_next.first_run = !j_started;
                    out_next.finished  = fin;
                    out_next.demoted   = dem;
                    out_next.time_left = time_dec;
                end
            end
            default:
            begin
                request.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        job_reg  <= job_next;
        len_reg  <= len_next;
        lvl_reg  <= lvl_next;
        out_reg  <= out_next;
    end

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && report.idle |->
            report.ran_job == '0 && !report.finished && !report.demoted
            && !report.first_run && report.time_left == '0)
        else $error("idle report carries job fields");

    a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && report.finished |-> report.time_left == '0)
        else $error("finished job reports time left");

    a_dem_top: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && report.demoted |-> report.ran_level == LVL_TOP && !report.finished)
        else $error("demotion from low level or with finish");

    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_PICK || $past(state_reg) == ST_EXEC)
        else $error("report raised outside a tick step");

endmodule

@@ hw/rtl/mlfq_regs.sv @@
// APB configuration registers: slice and allotment per level.
module mlfq_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mlfq_pkg::ADDR_W-1:0]   paddr,
    input  logic [mlfq_pkg::DATA_W-1:0]   pwdata,
    output logic [mlfq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output mlfq_pkg::cfg_t                cfg
);
    import mlfq_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TOP_SLICE: cfg_next.top_slice = pwdata[SLICE_W-1:0];
                REG_TOP_ALLOT: cfg_next.top_allot = pwdata[ALLOT_W-1:0];
                REG_LOW_SLICE: cfg_next.low_slice = pwdata[SLICE_W-1:0];
                REG_LOW_ALLOT: cfg_next.low_allot = pwdata[ALLOT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TOP_SLICE: prdata = DATA_W'(cfg_reg.top_slice);
            REG_TOP_ALLOT: prdata = DATA_W'(cfg_reg.top_allot);
            REG_LOW_SLICE: prdata = DATA_W'(cfg_reg.low_slice);
            REG_LOW_ALLOT: prdata = DATA_W'(cfg_reg.low_allot);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_slice <= TOP_SLICE_RST;
            cfg_reg.top_allot <= TOP_ALLOT_RST;
            cfg_reg.low_slice <= LOW_SLICE_RST;
            cfg_reg.low_allot <= LOW_ALLOT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/mlfq_queue.sv @@
// Both ready queues in one memory, addressed {level, slot}, with head/count per level.
module mlfq_queue #(
    parameter int JOBS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mlfq_pkg::queue_cmd_t      cmd,
    input  logic [$clog2(JOBS)-1:0]   push_id,
    output logic [$clog2(JOBS)-1:0]   head_id,
    output mlfq_pkg::queue_stat_t     stat
);
    import mlfq_pkg::*;

    localparam int PTR_W  = $clog2(JOBS);
    localparam int CNT_W  = $clog2(JOBS + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int QDEPTH = 2 * (2 ** PTR_W);

    logic [PTR_W-1:0] mem [QDEPTH];
    logic [PTR_W-1:0] rd_data_reg;

    logic [PTR_W-1:0] top_head_reg, top_head_next;
    logic [PTR_W-1:0] low_head_reg, low_head_next;
    logic [CNT_W-1:0] top_cnt_reg, top_cnt_next;
    logic [CNT_W-1:0] low_cnt_reg, low_cnt_next;
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W:0]   rd_addr;
    logic [PTR_W:0]   wr_addr;

    // tail slot = (head + count) mod JOBS; the sum stays below 2*JOBS
    function automatic logic [PTR_W-1:0] tail_slot(logic [PTR_W-1:0] head,
                                                  logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(cnt);
        if (sum >= SUM_W'(JOBS))
        begin
            sum = sum - SUM_W'(JOBS);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] head);
        logic [PTR_W-1:0] nxt;
        nxt = (head == PTR_W'(JOBS - 1)) ? '0 : head + PTR_W'(1);
        return nxt;
    endfunction

    assign rd_ptr  = (cmd.rd_lvl == LVL_TOP) ? top_head_reg : low_head_reg;
    assign wr_ptr  = (cmd.push_lvl == LVL_TOP) ? tail_slot(top_head_reg, top_cnt_reg)
                                               : tail_slot(low_head_reg, low_cnt_reg);
    assign rd_addr = {cmd.rd_lvl, rd_ptr};
    assign wr_addr = {cmd.push_lvl, wr_ptr};

    assign head_id       = rd_data_reg;
    assign stat.top_busy = (top_cnt_reg != '0);
    assign stat.low_busy = (low_cnt_reg != '0);

    always_comb
    begin
        top_head_next = top_head_reg;
        low_head_next = low_head_reg;
        top_cnt_next  = top_cnt_reg;
        low_cnt_next  = low_cnt_reg;
        if (cmd.push && cmd.push_lvl == LVL_TOP)
        begin
            top_cnt_next = top_cnt_next + CNT_W'(1);
        end
        if (cmd.push && cmd.push_lvl == LVL_LOW)
        begin
            low_cnt_next = low_cnt_next + CNT_W'(1);
        end
        if (cmd.pop && cmd.pop_lvl == LVL_TOP)
        begin
            top_head_next = next_slot(top_head_reg);
            top_cnt_next  = top_cnt_next - CNT_W'(1);
        end
        if (cmd.pop && cmd.pop_lvl == LVL_LOW)
        begin
            low_head_next = next_slot(low_head_reg);
            low_cnt_next  = low_cnt_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_head_reg <= '0;
            low_head_reg <= '0;
            top_cnt_reg  <= '0;
            low_cnt_reg  <= '0;
        end
        else
        begin
            top_head_reg <= top_head_next;
            low_head_reg <= low_head_next;
            top_cnt_reg  <= top_cnt_next;
            low_cnt_reg  <= low_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= push_id;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/mlfq_jobs.sv @@
// Per-job record memory (slice, allotment, time left) plus active/started flags.
module mlfq_jobs #(
    parameter int JOBS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mlfq_pkg::job_cmd_t        cmd,
    input  logic [$clog2(JOBS)-1:0]   idx,
    input  mlfq_pkg::job_rec_t        wr_rec,
    output mlfq_pkg::job_rec_t        rd_rec,
    output logic                      active,
    output logic                      started
);
    import mlfq_pkg::*;

    job_rec_t        mem [JOBS];
    job_rec_t        rd_rec_reg;
    logic [JOBS-1:0] active_reg, active_next;
    logic [JOBS-1:0] started_reg, started_next;

    assign rd_rec  = rd_rec_reg;
    assign active  = active_reg[idx];
    assign started = started_reg[idx];

    always_comb
    begin
        active_next  = active_reg;
        started_next = started_reg;
        if (cmd.arrive)
        begin
            active_next[idx]  = 1'b1;
            started_next[idx] = 1'b0;
        end
        if (cmd.run)
        begin
            started_next[idx] = 1'b1;
        end
        if (cmd.finish)
        begin
            active_next[idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            started_reg <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx] <= wr_rec;
        end
        if (cmd.rd_en)
        begin
            rd_rec_reg <= mem[idx];
        end
    end

endmodule
